### design/bsp_pkg.sv
// Shared widths, codes and types of the burst stream pacer.
`timescale 1ns / 1ps

package bsp_pkg;

    localparam int GAP_WIDTH         = 8;
    localparam int BURST_COUNT_WIDTH = 16;
    localparam int TOTAL_WIDTH       = 32;
    localparam int CFG_DATA_WIDTH    = 32;
    localparam int CFG_INDEX_WIDTH   = 1;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_TOTAL_BEATS = 1'b0,
        CFG_BURST_BEATS = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        PH_INIT  = 4'b0001,
        PH_DELAY = 4'b0010,
        PH_ACK   = 4'b0100,
        PH_DONE  = 4'b1000
    } phase_t;

endpackage

### design/bsp_in_if.sv
// Input channel of the pacer: one transaction per clock tick of the stream model, taken while ready is high.
`timescale 1ns / 1ps

interface bsp_in_if;
    logic                         valid;
    logic                         ready;
    logic                         restart;
    logic                         accepted;
    logic                         partner_last;
    logic [bsp_pkg::GAP_WIDTH-1:0] beat_gap;
    logic [bsp_pkg::GAP_WIDTH-1:0] burst_gap;

    modport source (
        output valid, restart, accepted, partner_last, beat_gap, burst_gap,
        input  ready
    );

    modport sink (
        input  valid, restart, accepted, partner_last, beat_gap, burst_gap,
        output ready
    );
endinterface

### design/bsp_out_if.sv
// Result channel of the pacer: active, last and finished flags for each tick.
`timescale 1ns / 1ps

interface bsp_out_if;
    logic valid;
    logic ready;
    logic active;
    logic last_beat;
    logic finished;

    modport source (
        output valid, active, last_beat, finished,
        input  ready
    );

    modport sink (
        input  valid, active, last_beat, finished,
        output ready
    );
endinterface

### design/burst_stream_pacer_unit.sv
// Top level of the burst stream pacer: state machine, beat counters and result register.
`timescale 1ns / 1ps

// Channel    Direction  Payload                                          Handshake
// in_ch      sink       restart, accepted, partner_last, beat/burst gap  valid/ready
// out_ch     source     active, last_beat, finished                      valid/ready
// cfg        write      cfg_we, cfg_index, cfg_data                      write enable
//
// The result of each transaction is registered into the output register in the cycle after it is taken.
// A new transaction is taken every cycle, limited only by the single output register.
// When a result is held by the sink, in_ch.ready falls until the result is taken.
// Reset puts the machine in its initial state with clear counters and no result pending.

module burst_stream_pacer_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    bsp_in_if.sink                                in_ch,
    bsp_out_if.source                             out_ch,
    input  logic                                  cfg_we,
    input  logic [bsp_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [bsp_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

    logic [bsp_pkg::TOTAL_WIDTH-1:0]       total_beats_reg;
    logic [bsp_pkg::BURST_COUNT_WIDTH-1:0] burst_beats_reg;

    bsp_pkg::phase_t                       phase_reg, phase_next;
    logic [bsp_pkg::TOTAL_WIDTH-1:0]       total_done_reg, total_done_next;
    logic [bsp_pkg::BURST_COUNT_WIDTH-1:0] burst_done_reg, burst_done_next;
    logic [bsp_pkg::GAP_WIDTH-1:0]         gap_left_reg, gap_left_next;
    logic                                  last_flag_reg, last_flag_next;

    logic out_valid_reg, out_valid_next;
    logic out_active_reg, out_last_reg, out_finished_reg;

    logic                                  in_accept;
    logic [bsp_pkg::TOTAL_WIDTH-1:0]       total_inc;
    logic [bsp_pkg::BURST_COUNT_WIDTH-1:0] burst_inc;
    logic [bsp_pkg::GAP_WIDTH-1:0]         gap_dec;
    logic [bsp_pkg::GAP_WIDTH-1:0]         gap_load;
    logic                                  act, burst_end, total_end, lst;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_accept   = in_ch.valid && in_ch.ready;

    assign total_inc = total_done_reg + bsp_pkg::TOTAL_WIDTH'(1);
    assign burst_inc = burst_done_reg + bsp_pkg::BURST_COUNT_WIDTH'(1);
    assign gap_dec   = gap_left_reg - bsp_pkg::GAP_WIDTH'(1);
    assign gap_load  = (last_flag_reg || in_ch.partner_last) ? in_ch.burst_gap : in_ch.beat_gap;

    always_comb
    begin
        phase_next      = phase_reg;
        total_done_next = total_done_reg;
        burst_done_next = burst_done_reg;
        gap_left_next   = gap_left_reg;
        if (in_ch.restart)
        begin
            phase_next      = bsp_pkg::PH_INIT;
            total_done_next = '0;
            burst_done_next = '0;
            gap_left_next   = '0;
        end
        else
        begin
            case (phase_reg)
                bsp_pkg::PH_INIT:
                begin
                    if ((total_beats_reg == '0) || (total_done_reg < total_beats_reg))
                    begin
                        gap_left_next = in_ch.burst_gap;
                        phase_next    = (in_ch.burst_gap != '0) ? bsp_pkg::PH_DELAY
                                                                : bsp_pkg::PH_ACK;
                    end
                    else
                    begin
                        phase_next = bsp_pkg::PH_DONE;
                    end
                end
                bsp_pkg::PH_DELAY:
                begin
                    gap_left_next = gap_dec;
                    if (gap_dec == '0)
                    begin
                        phase_next = bsp_pkg::PH_ACK;
                    end
                end
                bsp_pkg::PH_ACK:
                begin
                    if (in_ch.accepted)
                    begin
                        total_done_next = total_inc;
                        burst_done_next = burst_inc;
                        if ((total_beats_reg != '0) && (total_inc >= total_beats_reg))
                        begin
                            phase_next = bsp_pkg::PH_DONE;
                        end
                        else
                        begin
                            if (last_flag_reg || in_ch.partner_last)
                            begin
                                burst_done_next = '0;
                            end
                            gap_left_next = gap_load;
                            if (gap_load != '0)
                            begin
                                phase_next = bsp_pkg::PH_DELAY;
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    assign act       = (phase_next == bsp_pkg::PH_ACK);
    assign burst_end = (burst_beats_reg != '0) &&
                       (burst_done_next >= (burst_beats_reg - bsp_pkg::BURST_COUNT_WIDTH'(1)));
    assign total_end = (total_beats_reg != '0) &&
                       (total_done_next >= (total_beats_reg - bsp_pkg::TOTAL_WIDTH'(1)));
    assign lst            = act && (burst_end || total_end);
    assign last_flag_next = lst;

    always_comb
    begin
        if (in_accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_beats_reg <= '0;
            burst_beats_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (bsp_pkg::cfg_reg_t'(cfg_index))
                bsp_pkg::CFG_TOTAL_BEATS:
                begin
                    total_beats_reg <= cfg_data[bsp_pkg::TOTAL_WIDTH-1:0];
                end
                bsp_pkg::CFG_BURST_BEATS:
                begin
                    burst_beats_reg <= cfg_data[bsp_pkg::BURST_COUNT_WIDTH-1:0];
                end
                default:
                begin
                    total_beats_reg <= total_beats_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= bsp_pkg::PH_INIT;
            total_done_reg <= '0;
            burst_done_reg <= '0;
            gap_left_reg   <= '0;
            last_flag_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                phase_reg      <= phase_next;
                total_done_reg <= total_done_next;
                burst_done_reg <= burst_done_next;
                gap_left_reg   <= gap_left_next;
                last_flag_reg  <= last_flag_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_active_reg   <= act;
            out_last_reg     <= lst;
            out_finished_reg <= (phase_next == bsp_pkg::PH_DONE);
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.active    = out_active_reg;
    assign out_ch.last_beat = out_last_reg;
    assign out_ch.finished  = out_finished_reg;

    // A held result must stall the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |-> !in_ch.ready)
        else $error("input taken while a result is held");

    // A last beat is only ever flagged on an offered beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_last_reg || out_active_reg))
        else $error("last beat flagged without an active beat");

    // Offering a beat and being finished exclude each other.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_active_reg && out_finished_reg))
        else $error("active and finished together");

    // A restart transaction always yields an all-clear result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_ch.restart) |=> (out_valid_reg && !out_active_reg && !out_finished_reg))
        else $error("restart did not clear the result");

    // The done state is left only through a restart.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == bsp_pkg::PH_DONE) && !(in_accept && in_ch.restart))
            |=> (phase_reg == bsp_pkg::PH_DONE))
        else $error("done state left without restart");

endmodule
